FILE: sv/lpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared types and constants of the LED line pulse encoder.
// ----------------------------------------------------------------------------
package lpe_pkg;

  localparam int COLOR_W      = 8;
  localparam int TICK_W       = 8;
  localparam int DUR_W        = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int PIX_BITS     = 3 * COLOR_W;
  localparam int BIT_CNT_W    = $clog2(PIX_BITS);

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(PIX_BITS - 1);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH     = 3'd4;

  // reset timing, tuned for a 16 MHz clock
  localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 8'd12;
  localparam logic [TICK_W-1:0] ONE_LOW_RST   = 8'd6;
  localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 8'd6;
  localparam logic [TICK_W-1:0] ZERO_LOW_RST  = 8'd12;
  localparam int                LATCH_LOOPS   = 200;
  localparam logic [DUR_W-1:0]  LATCH_RST     = DUR_W'(LATCH_LOOPS * 3);

  typedef struct packed {
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] one_low;
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] zero_low;
    logic [DUR_W-1:0]  latch;
  } lpe_cfg_t;

  // one pixel in line order: green, red, blue, MSB first from bit 23 down
  typedef struct packed {
    logic [PIX_BITS-1:0] bits;
    logic                eof;
  } lpe_job_t;

endpackage

FILE: sv/lpe_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_ifs
// Valid/ready channels: pixel input and line segment output.
// ----------------------------------------------------------------------------
interface pixel_if;
  import lpe_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic               end_of_frame;

  modport source (output valid, red, green, blue, end_of_frame, input ready);
  modport sink   (input valid, red, green, blue, end_of_frame, output ready);
endinterface

interface segment_if;
  import lpe_pkg::*;
  logic             valid;
  logic             ready;
  logic             line_level;
  logic [DUR_W-1:0] duration;
  logic             last_segment;

  modport source (output valid, line_level, duration, last_segment, input ready);
  modport sink   (input valid, line_level, duration, last_segment, output ready);
endinterface

FILE: sv/lpe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_front
// Accepts pixels and packs them into line-order jobs, one register stage.
// ----------------------------------------------------------------------------
module lpe_front (
  input  logic             clk,
  input  logic             rst_n,
  pixel_if.sink            in_pixel,
  output lpe_pkg::lpe_job_t job,
  output logic             job_valid,
  input  logic             job_ready
);
  import lpe_pkg::*;

  logic     valid_r, valid_nxt;
  lpe_job_t job_r, job_nxt;
  logic     take;

  assign in_pixel.ready = !valid_r || job_ready;
  assign take           = in_pixel.valid && in_pixel.ready;

  always_comb begin
    valid_nxt = valid_r;
    job_nxt   = job_r;
    if (take) begin
      valid_nxt    = 1'b1;
      job_nxt.bits = {in_pixel.green, in_pixel.red, in_pixel.blue};
      job_nxt.eof  = in_pixel.end_of_frame;
    end else if (job_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    job_r <= job_nxt;
  end

  assign job       = job_r;
  assign job_valid = valid_r;

endmodule

FILE: sv/lpe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_queue
// Small job FIFO between the front and the segment sequencer.
// ----------------------------------------------------------------------------
module lpe_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lpe_pkg::lpe_job_t wr_job,
  input  logic              wr_valid,
  output logic              wr_ready,
  output lpe_pkg::lpe_job_t rd_job,
  output logic              rd_valid,
  input  logic              rd_ready
);
  import lpe_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lpe_job_t          mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              push, pop;

  assign wr_ready = (cnt_r != CNT_FULL);
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

FILE: sv/lpe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_back
// Segment sequencer: walks 24 pixel bits, a high and a low segment per bit,
// then the optional latch gap, into an output reg, one per unstalled cycle.
// ----------------------------------------------------------------------------
module lpe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  lpe_pkg::lpe_cfg_t cfg,
  input  lpe_pkg::lpe_job_t job,
  input  logic              job_valid,
  output logic              job_ready,
  segment_if.source         out_segment
);
  import lpe_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [PIX_BITS-1:0]  sr_r, sr_nxt;
  logic                 eof_r, eof_nxt;
  logic                 half_r, half_nxt;   // 0: high segment, 1: low segment
  logic                 latch_r, latch_nxt;
  logic [BIT_CNT_W-1:0] cnt_r, cnt_nxt;

  logic                 ovalid_r, ovalid_nxt;
  logic                 olevel_r, olevel_nxt;
  logic [DUR_W-1:0]     odur_r, odur_nxt;
  logic                 olast_r, olast_nxt;

  logic                 adv, work, fin, take, one, last_bit;
  logic [TICK_W-1:0]    hi_raw, lo_raw, hi_fix, lo_fix;
  logic [DUR_W-1:0]     latch_fix;

  assign adv      = !ovalid_r || out_segment.ready;
  assign work     = busy_r && adv;
  assign last_bit = (cnt_r == LAST_BIT);
  assign fin      = work && (latch_r || (half_r && last_bit && !eof_r));
  assign job_ready = !busy_r || fin;
  assign take     = job_valid && job_ready;

  assign one       = sr_r[PIX_BITS-1];
  assign hi_raw    = one ? cfg.one_high : cfg.zero_high;
  assign lo_raw    = one ? cfg.one_low  : cfg.zero_low;
  // a zero tick count is driven as one tick
  assign hi_fix    = (hi_raw == '0) ? TICK_W'(1) : hi_raw;
  assign lo_fix    = (lo_raw == '0) ? TICK_W'(1) : lo_raw;
  assign latch_fix = (cfg.latch == '0) ? DUR_W'(1) : cfg.latch;

  always_comb begin
    busy_nxt   = busy_r;
    sr_nxt     = sr_r;
    eof_nxt    = eof_r;
    half_nxt   = half_r;
    latch_nxt  = latch_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r;
    olevel_nxt = olevel_r;
    odur_nxt   = odur_r;
    olast_nxt  = olast_r;

    if (work) begin
      ovalid_nxt = 1'b1;
      if (latch_r) begin
        olevel_nxt = 1'b0;
        odur_nxt   = latch_fix;
        olast_nxt  = 1'b1;
        busy_nxt   = 1'b0;
      end else if (!half_r) begin
        olevel_nxt = 1'b1;
        odur_nxt   = DUR_W'(hi_fix);
        olast_nxt  = 1'b0;
        half_nxt   = 1'b1;
      end else begin
        olevel_nxt = 1'b0;
        odur_nxt   = DUR_W'(lo_fix);
        olast_nxt  = last_bit && !eof_r;
        half_nxt   = 1'b0;
        sr_nxt     = {sr_r[PIX_BITS-2:0], 1'b0};
        cnt_nxt    = cnt_r + 1'b1;
        if (last_bit) begin
          if (eof_r) begin
            latch_nxt = 1'b1;
          end else begin
            busy_nxt = 1'b0;
          end
        end
      end
    end else if (out_segment.ready) begin
      ovalid_nxt = 1'b0;
    end

    if (take) begin
      busy_nxt  = 1'b1;
      sr_nxt    = job.bits;
      eof_nxt   = job.eof;
      half_nxt  = 1'b0;
      latch_nxt = 1'b0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      half_r   <= 1'b0;
      latch_r  <= 1'b0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      half_r   <= half_nxt;
      latch_r  <= latch_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
    sr_r     <= sr_nxt;
    eof_r    <= eof_nxt;
    olevel_r <= olevel_nxt;
    odur_r   <= odur_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_segment.valid        = ovalid_r;
  assign out_segment.line_level   = olevel_r;
  assign out_segment.duration     = odur_r;
  assign out_segment.last_segment = olast_r;

endmodule

FILE: sv/led_pixel_pulse_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pixel_pulse_encoder_core
// Encodes RGB pixels into one-wire LED line segments (level, duration, last).
// ----------------------------------------------------------------------------
// Each pixel goes out green, red, blue, MSB first; every bit is a high then a
// low segment whose lengths come from the one/zero tick registers, and a
// pixel flagged end_of_frame gets a trailing low latch segment. The segment
// sequencer emits one segment per clock as long as the output side takes
// every transfer, so a pixel gives 48 segments, or 49 with the latch gap. A
// small job queue between the input stage and the sequencer lets the next
// pixels be accepted while the current one is still being sent.
module led_pixel_pulse_encoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pixel_if.sink                        in_pixel,
  segment_if.source                    out_segment,
  input  logic                         cfg_we,
  input  logic [lpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lpe_pkg::*;

  lpe_cfg_t cfg_r, cfg_nxt;
  lpe_job_t f_job, q_job;
  logic     f_valid, f_ready, q_valid, q_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ONE_HIGH:  cfg_nxt.one_high  = cfg_wdata[TICK_W-1:0];
        REG_ONE_LOW:   cfg_nxt.one_low   = cfg_wdata[TICK_W-1:0];
        REG_ZERO_HIGH: cfg_nxt.zero_high = cfg_wdata[TICK_W-1:0];
        REG_ZERO_LOW:  cfg_nxt.zero_low  = cfg_wdata[TICK_W-1:0];
        REG_LATCH:     cfg_nxt.latch     = cfg_wdata[DUR_W-1:0];
        default:       cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.one_high  <= ONE_HIGH_RST;
      cfg_r.one_low   <= ONE_LOW_RST;
      cfg_r.zero_high <= ZERO_HIGH_RST;
      cfg_r.zero_low  <= ZERO_LOW_RST;
      cfg_r.latch     <= LATCH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lpe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pixel  (in_pixel),
    .job       (f_job),
    .job_valid (f_valid),
    .job_ready (f_ready)
  );

  lpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_job   (f_job),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_job   (q_job),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  lpe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .job         (q_job),
    .job_valid   (q_valid),
    .job_ready   (q_ready),
    .out_segment (out_segment)
  );

  // a high segment never closes a pixel
  a_high_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_segment.valid && out_segment.line_level |-> !out_segment.last_segment)
    else $error("high segment flagged as last");

  // zero tick registers are stretched to one tick
  a_dur_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_segment.valid |-> out_segment.duration != '0)
    else $error("segment of zero duration");

  // the closing segment of a pixel is always low: the last bit's low half
  // or the latch gap
  a_last_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_segment.valid && out_segment.last_segment |-> !out_segment.line_level)
    else $error("last segment not low");

endmodule

FILE: bench/led_pixel_pulse_encoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pixel_pulse_encoder_core_tb
// Self-checking bench for the LED line pulse encoder. Pixels and register
// writes go in; a shadow encoder predicts every line segment, and each output
// transfer is compared in order against the oldest predicted segment.
// ----------------------------------------------------------------------------
module led_pixel_pulse_encoder_core_tb;
  import lpe_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 64;
  localparam int RANDOM_ITEMS   = 400;
  localparam int MAX_REPORTS    = 200;

  typedef struct packed {
    logic             level;
    logic [DUR_W-1:0] dur;
    logic             last;
  } segment_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pixel_if   pix_ch ();
  segment_if seg_ch ();

  led_pixel_pulse_encoder_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pixel    (pix_ch),
    .out_segment (seg_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  lpe_cfg_t line_cfg;
  segment_t pending_segments[$];
  int       error_count   = 0;
  int       idle_ticks    = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [DUR_W-1:0] ticks_or_one(input logic [DUR_W-1:0] v);
    return (v == '0) ? DUR_W'(1) : v;
  endfunction

  // Line order is green, red, blue, MSB first; each bit is high then low.
  function automatic void encode_pixel(input logic [COLOR_W-1:0] red, green, blue,
                                       input logic eof);
    logic [PIX_BITS-1:0] bits;
    segment_t            seg;
    int                  i;
    bits = {green, red, blue};
    for (i = PIX_BITS - 1; i >= 0; i--) begin
      seg.level = 1'b1;
      seg.dur   = ticks_or_one(bits[i] ? DUR_W'(line_cfg.one_high)
                                       : DUR_W'(line_cfg.zero_high));
      seg.last  = 1'b0;
      pending_segments.push_back(seg);
      seg.level = 1'b0;
      seg.dur   = ticks_or_one(bits[i] ? DUR_W'(line_cfg.one_low)
                                       : DUR_W'(line_cfg.zero_low));
      seg.last  = (i == 0) && !eof;
      pending_segments.push_back(seg);
    end
    if (eof) begin
      seg.level = 1'b0;
      seg.dur   = ticks_or_one(line_cfg.latch);
      seg.last  = 1'b1;
      pending_segments.push_back(seg);
    end
  endfunction

  function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ONE_HIGH:  line_cfg.one_high  = data[TICK_W-1:0];
      REG_ONE_LOW:   line_cfg.one_low   = data[TICK_W-1:0];
      REG_ZERO_HIGH: line_cfg.zero_high = data[TICK_W-1:0];
      REG_ZERO_LOW:  line_cfg.zero_low  = data[TICK_W-1:0];
      REG_LATCH:     line_cfg.latch     = data[DUR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void report(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void check_segment();
    segment_t want;
    if (pending_segments.size() == 0) begin
      report($sformatf("unexpected segment: expected none, actual level=%0b dur=%0d last=%0b",
                       seg_ch.line_level, seg_ch.duration, seg_ch.last_segment));
      return;
    end
    want = pending_segments.pop_front();
    if (seg_ch.line_level !== want.level)
      report($sformatf("line_level expected %0b actual %0b", want.level, seg_ch.line_level));
    if (seg_ch.duration !== want.dur)
      report($sformatf("duration expected %0d actual %0d", want.dur, seg_ch.duration));
    if (seg_ch.last_segment !== want.last)
      report($sformatf("last_segment expected %0b actual %0b", want.last,
                       seg_ch.last_segment));
  endfunction

  // Input side first so a same-edge bypass still finds its prediction.
  always @(posedge clk) begin
    if (rst_n && pix_ch.valid && pix_ch.ready)
      encode_pixel(pix_ch.red, pix_ch.green, pix_ch.blue, pix_ch.end_of_frame);
    if (rst_n && seg_ch.valid && seg_ch.ready)
      check_segment();
    if ((pix_ch.valid && pix_ch.ready) || (seg_ch.valid && seg_ch.ready))
      idle_ticks = 0;
    else
      idle_ticks = idle_ticks + 1;
    if (idle_ticks >= WATCHDOG_LIMIT) begin
      $display("led_pixel_pulse_encoder_core_tb: errors");
      $finish;
    end
  end

  initial begin
    seg_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      seg_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Returns at the falling edge after the transfer with valid still high.
  task automatic send_pixel(input logic [COLOR_W-1:0] red, green, blue, input logic eof);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid        <= 1'b1;
    pix_ch.red          <= red;
    pix_ch.green        <= green;
    pix_ch.blue         <= blue;
    pix_ch.end_of_frame <= eof;
    do @(posedge clk); while (!pix_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_segments(input int extra);
    pix_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_segments.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    shadow_write(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all_regs(input logic [CFG_DATA_W-1:0] data);
    write_reg(REG_ONE_HIGH, data);
    write_reg(REG_ONE_LOW, data);
    write_reg(REG_ZERO_HIGH, data);
    write_reg(REG_ZERO_LOW, data);
    write_reg(REG_LATCH, data);
  endtask

  function automatic logic [COLOR_W-1:0] rand_byte();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom_range(255));
    endcase
  endfunction

  task automatic randomize_regs();
    logic [CFG_DATA_W-1:0] data;
    int                    idx;
    for (idx = int'(REG_ONE_HIGH); idx <= int'(REG_LATCH); idx++) begin
      case ($urandom_range(5))
        0:       data = '0;
        1:       data = CFG_DATA_W'(1);
        2:       data = '1;
        default: data = CFG_DATA_W'($urandom);
      endcase
      write_reg(CFG_IDX_W'(idx), data);
    end
    if ($urandom_range(1) == 0)
      write_reg(CFG_IDX_W'($urandom_range(int'(REG_LATCH) + 1, (1 << CFG_IDX_W) - 1)),
                CFG_DATA_W'($urandom));
  endtask

  task automatic test_default_timing();
    send_pixel('0, '0, '0, 1'b0);
    send_pixel('1, '1, '1, 1'b1);
    send_pixel(8'hAA, 8'h55, 8'h0F, 1'b0);
    send_pixel(8'h80, 8'h01, 8'hF0, 1'b1);
    drain_segments(SETTLE_CYCLES);
  endtask

  task automatic test_register_extremes();
    int idx;
    write_all_regs('1);
    send_pixel(8'h5A, 8'hC3, 8'h81, 1'b1);
    send_pixel('1, '0, '1, 1'b0);
    send_pixel('0, '1, '0, 1'b1);
    drain_segments(SETTLE_CYCLES);
    write_all_regs(CFG_DATA_W'(1));
    send_pixel(8'h0F, 8'hF0, 8'h3C, 1'b0);
    send_pixel('1, '1, '1, 1'b1);
    send_pixel('0, '0, '0, 1'b1);
    drain_segments(SETTLE_CYCLES);
    // zero registers must still give one-tick segments
    write_all_regs('0);
    send_pixel(8'h96, 8'h69, 8'hA5, 1'b1);
    send_pixel('1, '0, '0, 1'b0);
    send_pixel('0, '0, '1, 1'b1);
    drain_segments(SETTLE_CYCLES);
    // upper data bits are dropped on the byte registers
    write_reg(REG_ONE_HIGH, 16'hFF03);
    write_reg(REG_ONE_LOW, 16'h8005);
    write_reg(REG_ZERO_HIGH, 16'h7F02);
    write_reg(REG_ZERO_LOW, 16'h0104);
    write_reg(REG_LATCH, 16'h8001);
    send_pixel(8'hE7, 8'h18, 8'h42, 1'b1);
    drain_segments(SETTLE_CYCLES);
    // writes past the last register change nothing
    for (idx = int'(REG_LATCH) + 1; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), 16'h0000);
    send_pixel(8'h01, 8'h80, 8'hFE, 1'b0);
    send_pixel(8'h7F, 8'hFE, 8'h01, 1'b1);
    drain_segments(SETTLE_CYCLES);
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      randomize_regs();
      for (n = 0; n < RANDOM_ITEMS / 3; n++) begin
        send_pixel(rand_byte(), rand_byte(), rand_byte(), $urandom_range(3) == 0);
        // sender holds off until the encoder has fully drained
        if (n == RANDOM_ITEMS / 6) drain_segments(0);
      end
      drain_segments(SETTLE_CYCLES);
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    pix_ch.valid        = 1'b0;
    pix_ch.red          = '0;
    pix_ch.green        = '0;
    pix_ch.blue         = '0;
    pix_ch.end_of_frame = 1'b0;
    line_cfg.one_high   = ONE_HIGH_RST;
    line_cfg.one_low    = ONE_LOW_RST;
    line_cfg.zero_high  = ZERO_HIGH_RST;
    line_cfg.zero_low   = ZERO_LOW_RST;
    line_cfg.latch      = LATCH_RST;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_timing();
    test_register_extremes();
    test_random_traffic();
    drain_segments(DRAIN_CYCLES);

    if (error_count == 0)
      $display("led_pixel_pulse_encoder_core_tb: clean");
    else
      $display("led_pixel_pulse_encoder_core_tb: errors");
    $finish;
  end

endmodule
